/* hw/rtl/stt_pkg.sv */
// Shared types and request codes for the software timer table.
package stt_pkg;

    localparam int ID_W       = 8;
    localparam int DEADLINE_W = 16;
    localparam int TIMEOUT_W  = 16;
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]       id;
        logic [DEADLINE_W-1:0] deadline;
        logic                  armed;
    } t_entry;

endpackage

/* hw/rtl/software_timer_table_unit.sv */
// Top level of the software timer table: request sequencer, slot scan and pending flags.
// A request beat is accepted in idle; the scan then reads one slot per cycle through the single
// table port, evaluates each slot after its registered read, claims a free slot for a create
// and finishes; an early create or update match ends the scan sooner.
// A new request beat is taken only after the result beat of the last one has been taken.
// Reset (synchronous, active low) frees every slot and clears the tick count and flags.
module software_timer_table_unit #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [stt_pkg::REQ_W-1:0]     i_req_type,
    input  logic [stt_pkg::ID_W-1:0]      i_msg_id,
    input  logic [stt_pkg::TIMEOUT_W-1:0] i_timeout_ticks,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_ok,
    output logic [stt_pkg::ID_W-1:0]      o_pending_flags
);
    import stt_pkg::*;

    // Slot index width and a scan counter wide enough to hold the slot count itself.
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_pend, n_pend;
    logic [IDX_W-1:0]      r_pend_idx, n_pend_idx;
    logic                  r_free_found, n_free_found;
    logic [IDX_W-1:0]      r_free_idx, n_free_idx;
    logic                  r_ok, n_ok;
    logic [ID_W-1:0]       r_flags, n_flags;
    logic [DEADLINE_W-1:0] r_tick, n_tick;
    logic [REQ_W-1:0]      r_type, n_type;
    logic [ID_W-1:0]       r_id, n_id;
    logic [TIMEOUT_W-1:0]  r_timeout, n_timeout;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    t_entry                rd_entry;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    t_entry                wr_entry;
    t_entry                arm_entry;
    logic                  id_match;
    logic                  is_arm_req;

    stt_table #(
        .NUM_TIMERS (NUM_TIMERS),
        .IDX_W      (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry)
    );

    // The deadline adder forms the deadline of an armed slot from the captured
    // tick count and timeout; the sum wraps at 2^16.
    always_comb begin
        arm_entry.id       = r_id;
        arm_entry.deadline = r_timeout + r_tick;
        arm_entry.armed    = 1'b1;
    end

    assign id_match   = (rd_entry.id == r_id);
    assign is_arm_req = (r_type == REQ_CREATE) || (r_type == REQ_UPDATE);

    // Sequencer. A request is captured in idle; the scan then issues one slot read
    // per cycle and evaluates the slot read in the previous cycle, so a write always
    // targets a slot other than the one being read. Update and create stop at the
    // first matching slot. Create also remembers the first free slot seen and arms
    // it once the whole table has been checked without a match.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_ok         = r_ok;
        n_flags      = r_flags;
        n_tick       = r_tick;
        n_type       = r_type;
        n_id         = r_id;
        n_timeout    = r_timeout;
        rd_en        = 1'b0;
        rd_addr      = r_idx[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_pend_idx;
        wr_entry     = arm_entry;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_type       = i_req_type;
                    n_id         = i_msg_id;
                    n_timeout    = i_timeout_ticks;
                    n_idx        = '0;
                    n_free_found = 1'b0;
                    n_ok         = 1'b0;
                    // A tick advances the count before the slots are compared with it.
                    if (i_req_type == REQ_TICK) begin
                        n_tick = r_tick + 1'b1;
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx < CNT_W'(NUM_TIMERS)) begin
                    rd_en      = 1'b1;
                    n_idx      = CNT_W'(r_idx + 1'b1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                end

                if (r_pend) begin
                    case (r_type) inside
                        REQ_CREATE, REQ_UPDATE: begin
                            if (id_match) begin
                                wr_en   = 1'b1;
                                n_flags = r_flags & ~r_id;
                                n_ok    = 1'b1;
                                n_state = S_OUT;
                            end else if (r_type == REQ_CREATE && rd_entry.id == '0
                                         && !r_free_found) begin
                                n_free_found = 1'b1;
                                n_free_idx   = r_pend_idx;
                            end
                        end
                        REQ_DELETE: begin
                            if (id_match) begin
                                wr_en    = 1'b1;
                                wr_entry = '0;
                                n_flags  = r_flags & ~r_id;
                            end
                        end
                        default: begin
                            if (rd_entry.id != '0 && rd_entry.armed
                                && rd_entry.deadline == r_tick) begin
                                wr_en          = 1'b1;
                                wr_entry       = rd_entry;
                                wr_entry.armed = 1'b0;
                                n_flags        = r_flags | rd_entry.id;
                            end
                        end
                    endcase
                end else if (r_idx == CNT_W'(NUM_TIMERS)) begin
                    // Every slot has been evaluated: claim the free slot for a create.
                    if (is_arm_req && r_type == REQ_CREATE && r_free_found) begin
                        wr_en   = 1'b1;
                        wr_addr = r_free_idx;
                        n_flags = r_flags & ~r_id;
                        n_ok    = 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_free_found <= 1'b0;
            r_ok         <= 1'b0;
            r_flags      <= '0;
            r_tick       <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend       <= n_pend;
            r_free_found <= n_free_found;
            r_ok         <= n_ok;
            r_flags      <= n_flags;
            r_tick       <= n_tick;
        end
    end

    // Request payload and the pending and free slot indices carry no reset.
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_free_idx <= n_free_idx;
        r_type     <= n_type;
        r_id       <= n_id;
        r_timeout  <= n_timeout;
    end

    // The block takes a new request beat only when idle; the result beat is held
    // in the status and flag registers until the downstream side takes it.
    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = (r_state == S_OUT);
    assign o_ok            = r_ok;
    assign o_pending_flags = r_flags;

endmodule

/* hw/rtl/stt_table.sv */
// Slot storage for the timer table: one memory with a registered read and per-slot valid bits.
module stt_table #(
    parameter int NUM_TIMERS = 8,
    parameter int IDX_W      = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output stt_pkg::t_entry   o_rd_entry,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  stt_pkg::t_entry   i_wr_entry
);
    import stt_pkg::*;

    t_entry                  r_mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   r_vld;
    t_entry                  r_rd_data;
    logic                    r_rd_vld;

    // A slot that was never written reads as a free, disarmed entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_vld ? r_rd_data : '0;

endmodule
